FILE: hw/rtl/kbfr_pkg.sv
// Shared types and constants for the keypad bus frame receiver.
package kbfr_pkg;

  localparam int MAX_FRAME_BYTES = 40;
  localparam int KEY_QUEUE_DEPTH = 8;
  localparam int JOB_FIFO_DEPTH  = 4;

  localparam int FRAME_LEN_W = 6;
  localparam int KEY_PTR_W   = (KEY_QUEUE_DEPTH > 1) ? $clog2(KEY_QUEUE_DEPTH) : 1;
  localparam int KEY_CNT_W   = $clog2(KEY_QUEUE_DEPTH + 1);
  localparam int JOB_PTR_W   = $clog2(JOB_FIFO_DEPTH);
  localparam int JOB_CNT_W   = $clog2(JOB_FIFO_DEPTH + 1);

  typedef logic [FRAME_LEN_W-1:0] frame_len_t;
  typedef logic [KEY_PTR_W-1:0]   key_ptr_t;
  typedef logic [KEY_CNT_W-1:0]   key_cnt_t;
  typedef logic [JOB_PTR_W-1:0]   job_ptr_t;
  typedef logic [JOB_CNT_W-1:0]   job_cnt_t;

  // frame status codes
  localparam logic [1:0] ST_GOOD_OURS  = 2'd0;
  localparam logic [1:0] ST_GOOD_OTHER = 2'd1;
  localparam logic [1:0] ST_CSUM_FAIL  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  // header bits
  localparam int HDR_ACK_BIT     = 2;
  localparam int STAT_WARN_BIT   = 2;
  localparam int STAT_ALARM_BIT  = 1;
  localparam logic [3:0] REPLY_HDR_LOW = 4'h2;
  localparam logic [7:0] NO_LAST_KEY   = 8'hFF;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] frame_status;
    logic       ack_seen;
    logic       warning_flag;
    logic       alarm_flag;
    logic       warning_rose;
    logic       alarm_rose;
    logic [7:0] reply_byte;
    logic       last;
  } out_item_t;

  // one frame event handed from front to back
  typedef struct packed {
    logic [1:0] frame_status;
    logic       ack_seen;
    logic       warning_flag;
    logic       alarm_flag;
    logic       warning_rose;
    logic       alarm_rose;
    logic [7:0] key_field;
  } job_t;

  // queue status seen by each side
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: hw/rtl/kbfr_front.sv
// Front end: frame parser, checksum, flags and key queue; emits one job per frame event.
module kbfr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               stall,
  input  kbfr_pkg::in_item_t in_item,
  input  logic [3:0]         device_id,
  output logic               job_valid,
  output kbfr_pkg::job_t     job
);

  logic                  in_frame, in_frame_next;
  logic [7:0]            previous_byte, previous_byte_next;
  kbfr_pkg::frame_len_t  frame_length, frame_length_next;
  logic [7:0]            running_sum, running_sum_next;
  logic [7:0]            header_byte, header_byte_next;
  logic [7:0]            status_byte, status_byte_next;
  logic                  warning_state, warning_state_next;
  logic                  alarm_state, alarm_state_next;
  logic [7:0]            last_key_field, last_key_field_next;
  kbfr_pkg::key_ptr_t    key_head, key_head_next;
  kbfr_pkg::key_ptr_t    key_tail, key_tail_next;
  kbfr_pkg::key_cnt_t    key_count, key_count_next;
  logic [7:0]            key_store [kbfr_pkg::KEY_QUEUE_DEPTH];

  logic                  accept;
  logic                  key_push;
  logic [7:0]            rx;
  logic [7:0]            cs;
  kbfr_pkg::frame_len_t  len_inc;
  logic                  for_us, ack, w, a;
  logic [7:0]            key_field;

  function automatic kbfr_pkg::key_ptr_t next_slot(input kbfr_pkg::key_ptr_t p);
    next_slot = (p == kbfr_pkg::key_ptr_t'(kbfr_pkg::KEY_QUEUE_DEPTH - 1))
              ? '0 : kbfr_pkg::key_ptr_t'(p + 1'b1);
  endfunction

  function automatic logic [3:0] map_key(input logic [7:0] k_in);
    logic [7:0] k;
    k = k_in;
    if (k >= "A" && k <= "Z") k = k + 8'd32;
    if (k >= "1" && k <= "9") map_key = 4'(k - "0");
    else if (k == "0") map_key = 4'ha;
    else if (k == "f" || k == "*") map_key = 4'hb;
    else if (k == "v" || k == "#") map_key = 4'hc;
    else if (k == "p") map_key = 4'hd;
    else if (k == "x" || k == ";" || k == "n") map_key = 4'he;
    else if (k == 8'd13 || k == "+" || k == "y") map_key = 4'hf;
    else map_key = 4'h0;
  endfunction

  assign accept = in_valid && !stall;
  assign rx     = in_item.data_byte;

  always_comb begin
    in_frame_next       = in_frame;
    previous_byte_next  = previous_byte;
    frame_length_next   = frame_length;
    running_sum_next    = running_sum;
    header_byte_next    = header_byte;
    status_byte_next    = status_byte;
    warning_state_next  = warning_state;
    alarm_state_next    = alarm_state;
    last_key_field_next = last_key_field;
    key_head_next       = key_head;
    key_tail_next       = key_tail;
    key_count_next      = key_count;
    key_push            = 1'b0;
    job_valid           = 1'b0;
    job                 = '0;
    cs                  = running_sum;
    len_inc             = kbfr_pkg::frame_len_t'(frame_length + 1'b1);
    for_us              = (header_byte[7:4] == device_id);
    ack                 = header_byte[kbfr_pkg::HDR_ACK_BIT];
    w                   = status_byte[kbfr_pkg::STAT_WARN_BIT];
    a                   = status_byte[kbfr_pkg::STAT_ALARM_BIT];
    key_field           = '0;

    if (accept) begin
      if (in_item.func) begin
        if (key_count < kbfr_pkg::key_cnt_t'(kbfr_pkg::KEY_QUEUE_DEPTH)) begin
          key_push       = 1'b1;
          key_tail_next  = next_slot(key_tail);
          key_count_next = kbfr_pkg::key_cnt_t'(key_count + 1'b1);
        end
      end else if (!in_frame) begin
        if (previous_byte == 8'd0 && rx != 8'd0) begin
          in_frame_next     = 1'b1;
          frame_length_next = kbfr_pkg::frame_len_t'(1);
          running_sum_next  = '0;
          header_byte_next  = rx;
          status_byte_next  = '0;
        end
        previous_byte_next = rx;
      end else begin
        previous_byte_next = rx;
        frame_length_next  = len_inc;
        if (frame_length == kbfr_pkg::frame_len_t'(1)) status_byte_next = rx;
        if (rx != 8'd0) begin
          running_sum_next = running_sum + previous_byte;
          if (len_inc >= kbfr_pkg::frame_len_t'(kbfr_pkg::MAX_FRAME_BYTES)) begin
            in_frame_next      = 1'b0;
            job_valid          = 1'b1;
            job.frame_status   = kbfr_pkg::ST_OVERFLOW;
            job.warning_flag   = warning_state;
            job.alarm_flag     = alarm_state;
          end
        end else begin
          // terminator: previous byte was the checksum
          in_frame_next = 1'b0;
          job_valid     = 1'b1;
          if (cs == 8'd0) cs = 8'd1;
          // status byte is taken from rx when the frame is header and zero only
          if (frame_length == kbfr_pkg::frame_len_t'(1)) begin
            w = 1'b0;
            a = 1'b0;
          end
          if (cs != previous_byte) begin
            job.frame_status = kbfr_pkg::ST_CSUM_FAIL;
            job.warning_flag = warning_state;
            job.alarm_flag   = alarm_state;
          end else begin
            warning_state_next = w;
            alarm_state_next   = a;
            job.warning_flag   = w;
            job.alarm_flag     = a;
            job.warning_rose   = w && !warning_state;
            job.alarm_rose     = a && !alarm_state;
            if (!for_us) begin
              job.frame_status = kbfr_pkg::ST_GOOD_OTHER;
            end else begin
              job.frame_status = kbfr_pkg::ST_GOOD_OURS;
              job.ack_seen     = ack;
              if (ack) begin
                if (key_count != '0) begin
                  key_field      = {map_key(key_store[key_head]), 4'h0};
                  key_head_next  = next_slot(key_head);
                  key_count_next = kbfr_pkg::key_cnt_t'(key_count - 1'b1);
                end
                last_key_field_next = key_field;
              end else begin
                key_field = (last_key_field == kbfr_pkg::NO_LAST_KEY) ? 8'd0
                                                                       : last_key_field;
              end
              job.key_field = key_field;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      previous_byte  <= 8'hFF;
      frame_length   <= '0;
      running_sum    <= '0;
      header_byte    <= '0;
      status_byte    <= '0;
      warning_state  <= 1'b0;
      alarm_state    <= 1'b0;
      last_key_field <= kbfr_pkg::NO_LAST_KEY;
      key_head       <= '0;
      key_tail       <= '0;
      key_count      <= '0;
    end else begin
      in_frame       <= in_frame_next;
      previous_byte  <= previous_byte_next;
      frame_length   <= frame_length_next;
      running_sum    <= running_sum_next;
      header_byte    <= header_byte_next;
      status_byte    <= status_byte_next;
      warning_state  <= warning_state_next;
      alarm_state    <= alarm_state_next;
      last_key_field <= last_key_field_next;
      key_head       <= key_head_next;
      key_tail       <= key_tail_next;
      key_count      <= key_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (key_push) begin
      key_store[key_tail] <= rx;
    end
  end

endmodule

FILE: hw/rtl/kbfr_job_fifo.sv
// Short job queue between the front end and the result sequencer.
module kbfr_job_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  kbfr_pkg::job_t       push_job,
  input  logic                 pop,
  output kbfr_pkg::job_t       head_job,
  output kbfr_pkg::fifo_stat_t stat
);

  kbfr_pkg::job_t   mem [kbfr_pkg::JOB_FIFO_DEPTH];
  kbfr_pkg::job_ptr_t wr_ptr, rd_ptr;
  kbfr_pkg::job_cnt_t count, count_next;
  logic do_push, do_pop;

  assign stat.full  = (count == kbfr_pkg::job_cnt_t'(kbfr_pkg::JOB_FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) count_next = kbfr_pkg::job_cnt_t'(count + 1'b1);
    if (!do_push && do_pop) count_next = kbfr_pkg::job_cnt_t'(count - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) wr_ptr <= kbfr_pkg::job_ptr_t'(wr_ptr + 1'b1);
      if (do_pop)  rd_ptr <= kbfr_pkg::job_ptr_t'(rd_ptr + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

endmodule

FILE: hw/rtl/kbfr_back.sv
// Result sequencer: turns each job into a status item and, for our frames, four reply items.
module kbfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  kbfr_pkg::job_t       head_job,
  input  kbfr_pkg::fifo_stat_t fifo_stat,
  output logic                 pop,
  input  logic [3:0]           device_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kbfr_pkg::out_item_t  out_item
);

  typedef enum logic [4:0] {
    SEQ_STATUS = 5'b00001,
    SEQ_HDR    = 5'b00010,
    SEQ_KEY    = 5'b00100,
    SEQ_ZERO   = 5'b01000,
    SEQ_SUM    = 5'b10000
  } seq_state_t;

  seq_state_t          state, state_next;
  logic [7:0]          key_field, key_field_next;
  logic                out_valid_next;
  kbfr_pkg::out_item_t out_item_next;
  logic                load;
  logic [7:0]          hdr;

  assign load = !out_valid || !out_stall;
  assign hdr  = {device_id, kbfr_pkg::REPLY_HDR_LOW};

  always_comb begin
    state_next     = state;
    key_field_next = key_field;
    out_valid_next = out_valid;
    out_item_next  = out_item;
    pop            = 1'b0;
    if (load) begin
      out_item_next      = '0;
      out_item_next.kind = kbfr_pkg::KIND_REPLY;
      out_valid_next     = 1'b1;
      unique case (state)
        SEQ_STATUS: begin
          out_item_next.kind = kbfr_pkg::KIND_STATUS;
          if (fifo_stat.empty) begin
            out_valid_next = 1'b0;
          end else begin
            pop                        = 1'b1;
            out_item_next.frame_status = head_job.frame_status;
            out_item_next.ack_seen     = head_job.ack_seen;
            out_item_next.warning_flag = head_job.warning_flag;
            out_item_next.alarm_flag   = head_job.alarm_flag;
            out_item_next.warning_rose = head_job.warning_rose;
            out_item_next.alarm_rose   = head_job.alarm_rose;
            if (head_job.frame_status == kbfr_pkg::ST_GOOD_OURS) begin
              key_field_next = head_job.key_field;
              state_next     = SEQ_HDR;
            end else begin
              out_item_next.last = 1'b1;
            end
          end
        end
        SEQ_HDR: begin
          out_item_next.reply_byte = hdr;
          state_next               = SEQ_KEY;
        end
        SEQ_KEY: begin
          out_item_next.reply_byte = key_field;
          state_next               = SEQ_ZERO;
        end
        SEQ_ZERO: begin
          state_next = SEQ_SUM;
        end
        SEQ_SUM: begin
          out_item_next.reply_byte = hdr + key_field;
          out_item_next.last       = 1'b1;
          state_next               = SEQ_STATUS;
        end
        default: begin
          out_valid_next = 1'b0;
          state_next     = SEQ_STATUS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_STATUS;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key_field <= key_field_next;
    out_item  <= out_item_next;
  end

endmodule

FILE: hw/rtl/keypad_bus_frame_receiver.sv
// Keypad bus frame receiver, top level.
// Takes one item per cycle while in_stall is low: a line byte from the panel (func 0)
// or a host key press (func 1). The front end parses zero-delimited frames with a
// running checksum, keeps the warning/alarm flags and the key queue, and finishes
// each item in the cycle it is accepted. Every frame end or overflow becomes one job
// in a four-entry queue. The result sequencer turns a job into one status item,
// followed by four reply items when the frame was good and addressed to device_id;
// it emits one item per cycle from a registered output while out_stall is low, so a
// job yields one or five output items. in_stall rises only when the job queue is
// full, so input runs at one item per cycle unless frames for this keypad arrive
// faster than one per five line bytes or the output is held off. device_id must be
// written through cfg_we/cfg_data while the block is idle; the block does not enforce it.
module keypad_bus_frame_receiver (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  kbfr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output kbfr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data
);

  logic [3:0]           device_id;
  logic                 job_valid;
  kbfr_pkg::job_t       job;
  kbfr_pkg::job_t       head_job;
  kbfr_pkg::fifo_stat_t fifo_stat;
  logic                 pop;

  // keypad address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= '0;
    end else if (cfg_we) begin
      device_id <= cfg_data;
    end
  end

  // input is held off only while the job queue is full
  assign in_stall = fifo_stat.full;

  kbfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .stall     (fifo_stat.full),
    .in_item   (in_item),
    .device_id (device_id),
    .job_valid (job_valid),
    .job       (job)
  );

  kbfr_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_job (job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  kbfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .device_id (device_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: bench/tb_keypad_bus_frame_receiver.sv
`timescale 1ns / 100ps
// Self-checking testbench for the keypad bus frame receiver: directed table, then random frames.
module tb_keypad_bus_frame_receiver;

  // watchdog: cycles with no handshake on any port before the run is called hung
  localparam int QUIET_LIMIT = 4000;
  // long receiver hold-off used to fill the job queue and back up the input
  localparam int HOLD_CYCLES = 80;

  // item kinds on the input side
  localparam logic FN_LINE = 1'b0;
  localparam logic FN_KEY  = 1'b1;

  // mapped key codes as carried in the upper nibble of the key field
  localparam logic [3:0] KC_NONE  = 4'h0;
  localparam logic [3:0] KC_ZERO  = 4'hA;
  localparam logic [3:0] KC_STAR  = 4'hB;
  localparam logic [3:0] KC_HASH  = 4'hC;
  localparam logic [3:0] KC_P     = 4'hD;
  localparam logic [3:0] KC_X     = 4'hE;
  localparam logic [3:0] KC_ENTER = 4'hF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  kbfr_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  kbfr_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic [3:0]          cfg_data = 4'h0;

  keypad_bus_frame_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Receiver shadow: line parser, flags and key queue as the block should hold them.
  // Starts at reset values; reset is applied only once, at time zero.
  // ---------------------------------------------------------------------------
  logic [3:0]           dev_id = 4'h0;
  logic                 rx_in_frame = 1'b0;
  logic [7:0]           rx_prev = 8'hFF;       // newest line byte, seeded non-zero
  kbfr_pkg::frame_len_t rx_len = '0;
  logic [7:0]           rx_sum = 8'h00;        // sum of frame bytes except the newest
  logic [7:0]           rx_hdr = 8'h00;
  logic [7:0]           rx_stat = 8'h00;
  logic                 warn_on = 1'b0;
  logic                 alarm_on = 1'b0;
  logic [7:0]           resend_field = kbfr_pkg::NO_LAST_KEY;
  logic [7:0]           key_mem [kbfr_pkg::KEY_QUEUE_DEPTH];
  kbfr_pkg::key_ptr_t   key_rd = '0;
  kbfr_pkg::key_ptr_t   key_wr = '0;
  kbfr_pkg::key_cnt_t   key_cnt = '0;

  kbfr_pkg::out_item_t  pending_results [$];   // results owed by the block, oldest first
  int                   mismatches = 0;
  int                   results_seen = 0;

  function automatic kbfr_pkg::key_ptr_t bump(kbfr_pkg::key_ptr_t p);
    return (p == kbfr_pkg::key_ptr_t'(kbfr_pkg::KEY_QUEUE_DEPTH - 1))
           ? '0 : kbfr_pkg::key_ptr_t'(p + 1'b1);
  endfunction

  // host key press to keypad code: letters fold to lower case first
  function automatic logic [3:0] keycode_of(logic [7:0] k);
    logic [7:0] c;
    c = (k >= "A" && k <= "Z") ? k + 8'd32 : k;
    if (c >= "1" && c <= "9") return 4'(c - "0");
    case (c)
      "0":                 return KC_ZERO;
      "f", "*":            return KC_STAR;
      "v", "#":            return KC_HASH;
      "p":                 return KC_P;
      "x", ";", "n":       return KC_X;
      8'h0d, "+", "y":     return KC_ENTER;
      default:             return KC_NONE;
    endcase
  endfunction

  // status result; flags are whatever the shadow holds after the frame
  function automatic kbfr_pkg::out_item_t status_item(logic [1:0] st, logic ack, logic wr,
                                                      logic ar, logic lst);
    kbfr_pkg::out_item_t s;
    s = '0;
    s.kind         = kbfr_pkg::KIND_STATUS;
    s.frame_status = st;
    s.ack_seen     = ack;
    s.warning_flag = warn_on;
    s.alarm_flag   = alarm_on;
    s.warning_rose = wr;
    s.alarm_rose   = ar;
    s.last         = lst;
    return s;
  endfunction

  function automatic kbfr_pkg::out_item_t reply_item(logic [7:0] b, logic lst);
    kbfr_pkg::out_item_t r;
    r = '0;
    r.kind       = kbfr_pkg::KIND_REPLY;
    r.reply_byte = b;
    r.last       = lst;
    return r;
  endfunction

  // a directed row may pin the status code by hand; the rest comes from the shadow
  function automatic void queue_status(kbfr_pkg::out_item_t s, logic pin, logic [1:0] pin_st);
    if (pin) s.frame_status = pin_st;
    pending_results.push_back(s);
  endfunction

  // Advance the shadow by one accepted item and queue the results it causes.
  function automatic void advance_receiver(kbfr_pkg::in_item_t it, logic pin,
                                           logic [1:0] pin_st);
    logic [7:0] b, cs, ck, kf, h0;
    logic       w, a, wr, ar, ack;
    b = it.data_byte;

    // key press: into the queue unless it is full, never a result
    if (it.func == FN_KEY) begin
      if (key_cnt < kbfr_pkg::KEY_QUEUE_DEPTH) begin
        key_mem[key_wr] = b;
        key_wr = bump(key_wr);
        key_cnt = key_cnt + 1'b1;
      end
      return;
    end

    // between frames: a non-zero byte right after a zero opens a frame
    if (!rx_in_frame) begin
      if (rx_prev == 8'h00) begin
        if (b == 8'h00) return;        // repeated zero leaves everything alone
        rx_in_frame = 1'b1;
        rx_len      = kbfr_pkg::frame_len_t'(1);
        rx_sum      = 8'h00;
        rx_hdr      = b;
        rx_stat     = 8'h00;
      end
      rx_prev = b;
      return;
    end

    // inside a frame: the byte before this one joins the sum unless this ends the frame
    if (b != 8'h00) rx_sum = rx_sum + rx_prev;
    if (rx_len == kbfr_pkg::frame_len_t'(1)) rx_stat = b;
    cs      = rx_sum;
    ck      = rx_prev;                 // checksum byte when b is the terminator
    rx_prev = b;
    rx_len  = rx_len + 1'b1;

    if (b != 8'h00) begin
      if (rx_len >= kbfr_pkg::MAX_FRAME_BYTES) begin
        rx_in_frame = 1'b0;
        queue_status(status_item(kbfr_pkg::ST_OVERFLOW, 1'b0, 1'b0, 1'b0, 1'b1),
                     pin, pin_st);
      end
      return;
    end

    rx_in_frame = 1'b0;
    if (cs == 8'h00) cs = 8'h01;
    if (cs != ck) begin
      queue_status(status_item(kbfr_pkg::ST_CSUM_FAIL, 1'b0, 1'b0, 1'b0, 1'b1),
                   pin, pin_st);
      return;
    end

    // good frame: flags follow the status byte, rises against the old state
    w        = rx_stat[kbfr_pkg::STAT_WARN_BIT];
    a        = rx_stat[kbfr_pkg::STAT_ALARM_BIT];
    wr       = w && !warn_on;
    ar       = a && !alarm_on;
    warn_on  = w;
    alarm_on = a;

    if (rx_hdr[7:4] != dev_id) begin
      queue_status(status_item(kbfr_pkg::ST_GOOD_OTHER, 1'b0, wr, ar, 1'b1), pin, pin_st);
      return;
    end

    ack = rx_hdr[kbfr_pkg::HDR_ACK_BIT];
    queue_status(status_item(kbfr_pkg::ST_GOOD_OURS, ack, wr, ar, 1'b0), pin, pin_st);

    // acked: pop a fresh key; not acked: resend the previous key field
    if (ack) begin
      kf = 8'h00;
      if (key_cnt != 0) begin
        kf = {keycode_of(key_mem[key_rd]), 4'h0};
        key_rd = bump(key_rd);
        key_cnt = key_cnt - 1'b1;
      end
      resend_field = kf;
    end else begin
      kf = (resend_field == kbfr_pkg::NO_LAST_KEY) ? 8'h00 : resend_field;
    end

    h0 = {dev_id, kbfr_pkg::REPLY_HDR_LOW};
    pending_results.push_back(reply_item(h0, 1'b0));
    pending_results.push_back(reply_item(kf, 1'b0));
    pending_results.push_back(reply_item(8'h00, 1'b0));
    pending_results.push_back(reply_item(h0 + kf, 1'b1));
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_result(kbfr_pkg::out_item_t got);
    kbfr_pkg::out_item_t want;
    string               bad;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("result %0d (%h) with nothing expected", results_seen, got));
      return;
    end
    want = pending_results.pop_front();
    bad  = "";
    if (got.kind !== want.kind)                 bad = {bad, " kind"};
    if (got.frame_status !== want.frame_status) bad = {bad, " frame_status"};
    if (got.ack_seen !== want.ack_seen)         bad = {bad, " ack_seen"};
    if (got.warning_flag !== want.warning_flag) bad = {bad, " warning_flag"};
    if (got.alarm_flag !== want.alarm_flag)     bad = {bad, " alarm_flag"};
    if (got.warning_rose !== want.warning_rose) bad = {bad, " warning_rose"};
    if (got.alarm_rose !== want.alarm_rose)     bad = {bad, " alarm_rose"};
    if (got.reply_byte !== want.reply_byte)     bad = {bad, " reply_byte"};
    if (got.last !== want.last)                 bad = {bad, " last"};
    if (bad != "")
      flag_mismatch($sformatf("result %0d:%s got %h want %h", results_seen, bad, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      check_result(out_item);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts while idling is on, plus an on-demand long
  // hold-off counted here so the job queue fills and in_stall has to rise.
  // ---------------------------------------------------------------------------
  logic idle_en = 1'b0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: any handshake or register write counts as progress
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  logic [7:0] line_last = 8'hFF;      // last line byte offered, tracks frame openings
  int         sent_items = 0;

  // Offer one item and hold it until taken. Valid only drops for an idle gap.
  task automatic push_item(kbfr_pkg::in_item_t it, logic pin, logic [1:0] pin_st);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    advance_receiver(it, pin, pin_st);
    if (it.func == FN_LINE) line_last = it.data_byte;
  endtask

  task automatic send_line(logic [7:0] b);
    sent_items++;
    push_item(kbfr_pkg::in_item_t'{FN_LINE, b}, 1'b0, kbfr_pkg::ST_GOOD_OURS);
  endtask

  task automatic send_key(logic [7:0] k);
    sent_items++;
    push_item(kbfr_pkg::in_item_t'{FN_KEY, k}, 1'b0, kbfr_pkg::ST_GOOD_OURS);
  endtask

  // mostly keys that map, some CR, some arbitrary bytes
  function automatic logic [7:0] pick_key();
    string keyset;
    int    k;
    keyset = "0123456789fFvVpPxXnNyY*#;+aZ";
    k = $urandom_range(0, 9);
    if (k == 0) return 8'h0d;
    if (k < 3) return 8'($urandom_range(0, 255));
    return keyset[$urandom_range(0, keyset.len() - 1)];
  endfunction

  // One frame: zero first if needed, header, body, checksum, terminator.
  // body_len 0 sends the header alone; 39 or more runs into overflow.
  task automatic send_frame(logic [7:0] hdr, int body_len, logic bad_sum);
    logic [7:0] sum, b;
    if (line_last != 8'h00) send_line(8'h00);
    send_line(hdr);
    sum = hdr;
    for (int i = 0; i < body_len; i++) begin
      b = 8'($urandom_range(1, 255));
      sum = sum + b;
      send_line(b);
    end
    if (body_len > 0) begin
      if (sum == 8'h00) sum = 8'h01;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      send_line(sum);
    end
    send_line(8'h00);
  endtask

  // Random traffic: mostly well-formed frames, some for us, some not, with key
  // presses, noise, repeated zeros, bad checksums and the odd overflow mixed in.
  task automatic run_random(int target);
    int         start, pick, body;
    logic [7:0] hdr;
    start = sent_items;
    while (sent_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 3)) send_key(pick_key());
      end else if (pick < 20) begin
        // line noise; not counted, may open or break frames
        repeat ($urandom_range(1, 3))
          push_item(kbfr_pkg::in_item_t'{FN_LINE, 8'($urandom_range(0, 255))}, 1'b0,
                    kbfr_pkg::ST_GOOD_OURS);
      end else begin
        hdr = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 2) != 0) hdr[7:4] = dev_id;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          body = $urandom_range(39, 42);
        end else if (pick < 8) begin
          body = 0;
          if ($urandom_range(0, 1) == 0) hdr = 8'h01;   // the only header that is its own sum
        end else begin
          body = $urandom_range(1, 6);
        end
        if (hdr == 8'h00) hdr = 8'h01;
        send_frame(hdr, body, $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) == 0) send_line(8'h00);
      end
    end
  endtask

  // Register write while idle: everything owed has come out, plus a short margin.
  task automatic write_device_id(logic [3:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dev_id = v;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, run with device_id 0. Rows with a status pinned carry the
  // code read straight off the frame; replies still come from the shadow.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic       func;
    logic [7:0] val;
    logic [7:0] reps;
    logic       pin;
    logic [1:0] pin_st;
  } stim_row_t;

  localparam int N_ROWS = 29;

  stim_row_t directed [N_ROWS] = '{
    '{FN_LINE, 8'h00, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // zero arms the parser
    '{FN_LINE, 8'h00, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // repeated zero, ignored
    '{FN_LINE, 8'h01, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // header is its own checksum
    '{FN_LINE, 8'h00, 8'd1,  1'b1, kbfr_pkg::ST_GOOD_OURS},   //   no ack, nothing to resend
    '{FN_LINE, 8'h15, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // bad checksum
    '{FN_LINE, 8'h06, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h33, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h00, 8'd1,  1'b1, kbfr_pkg::ST_CSUM_FAIL},
    '{FN_LINE, 8'h15, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // right sum, other keypad
    '{FN_LINE, 8'h06, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   //   warning and alarm rise
    '{FN_LINE, 8'h1B, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h00, 8'd1,  1'b1, kbfr_pkg::ST_GOOD_OTHER},
    '{FN_KEY,  8'h35, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // '5'
    '{FN_KEY,  8'h59, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // 'Y', folds to enter
    '{FN_LINE, 8'h04, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // ack: pops '5', flags fall
    '{FN_LINE, 8'h01, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h05, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h00, 8'd1,  1'b1, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h01, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // no ack: resends '5' field
    '{FN_LINE, 8'h00, 8'd1,  1'b1, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'hFF, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // all-ones frame hits the cap
    '{FN_LINE, 8'hFF, 8'd39, 1'b1, kbfr_pkg::ST_OVERFLOW},
    '{FN_KEY,  8'h00, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // extremes into the key queue
    '{FN_KEY,  8'hFF, 8'd9,  1'b0, kbfr_pkg::ST_GOOD_OURS},   //   last pushes hit full queue
    '{FN_LINE, 8'h00, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // zero needed after overflow
    '{FN_LINE, 8'h04, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},   // ack pops 'Y', flags rise
    '{FN_LINE, 8'h06, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h0A, 8'd1,  1'b0, kbfr_pkg::ST_GOOD_OURS},
    '{FN_LINE, 8'h00, 8'd1,  1'b1, kbfr_pkg::ST_GOOD_OURS}
  };

  initial begin
    logic [7:0] hdr;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, idling on both sides
    idle_en = 1'b1;
    write_device_id(4'h0);
    for (int r = 0; r < N_ROWS; r++)
      for (int n = 0; n < directed[r].reps; n++)
        push_item(kbfr_pkg::in_item_t'{directed[r].func, directed[r].val}, directed[r].pin,
                  directed[r].pin_st);

    // highest address, random traffic with idling
    write_device_id(4'hF);
    run_random(40);

    // back-pressure: receiver holds off while acked frames for us keep coming,
    // each one owing five results, so the job queue fills and stalls the input
    idle_en = 1'b0;
    repeat (4) send_key(pick_key());
    hold_requests++;
    hdr = {dev_id, 4'h0};
    hdr[kbfr_pkg::HDR_ACK_BIT] = 1'b1;
    repeat (10) send_frame(hdr, 1, 1'b0);

    // some middle address, idling again
    write_device_id(4'($urandom_range(1, 14)));
    idle_en = 1'b1;
    run_random(35);

    // lowest address, last stretch runs flat out
    write_device_id(4'h0);
    idle_en = 1'b0;
    run_random(35);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
